/* rtl/assert_macros.svh */
// Assertion macros shared by the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked through reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/hbat_pkg.sv */
// Shared types, constants and helpers of the heap byte accounting trigger.
`default_nettype none

package hbat_pkg;

   localparam int COUNT_BITS  = 48;
   localparam int MIN_BITS    = 48;
   localparam int FACTOR_BITS = 8;
   localparam int SIZE_BITS   = 32;
   localparam int OUT_BITS    = 48;
   localparam int CSR_BITS    = 48;
   localparam int WIDE_BITS   = (COUNT_BITS > MIN_BITS) ? COUNT_BITS : MIN_BITS;

   typedef logic [COUNT_BITS-1:0]  cnt_type;
   typedef logic [MIN_BITS-1:0]    min_type;
   typedef logic [FACTOR_BITS-1:0] factor_type;
   typedef logic [SIZE_BITS-1:0]   size_type;
   typedef logic [OUT_BITS-1:0]    out_type;

   localparam cnt_type CNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [2:0] {
      OP_ALLOC      = 3'd0,
      OP_RESIZE     = 3'd1,
      OP_ENV_ALLOC  = 3'd2,
      OP_POLL       = 3'd3,
      OP_BEGIN      = 3'd4,
      OP_RECOMP_YNG = 3'd5,
      OP_RECOMP_FUL = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_FULL  = 2'd1,
      ACT_YOUNG = 2'd2
   } action_type;

   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_YOUNG_FACTOR = 2'd0;
   localparam csr_idx_type CSR_YOUNG_MIN    = 2'd1;
   localparam csr_idx_type CSR_HEAP_FACTOR  = 2'd2;
   localparam csr_idx_type CSR_HEAP_MIN     = 2'd3;

   localparam factor_type RESET_FACTOR    = 8'd2;
   localparam min_type    RESET_MIN_BYTES = 48'd1048576;

   // Clamp a floor value to the counter range.
   function automatic cnt_type clamp_min(input min_type v);
      logic [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(v);
      if (w > WIDE_BITS'(CNT_MAX)) begin
         return CNT_MAX;
      end
      return COUNT_BITS'(w);
   endfunction

   localparam cnt_type LIMIT_RESET = clamp_min(RESET_MIN_BYTES);

endpackage

`default_nettype wire

/* rtl/hbat_thresh.sv */
// Threshold recompute: bytes times factor, saturated, floored at a minimum.
`default_nettype none

module hbat_thresh (
   input  hbat_pkg::cnt_type    bytes,
   input  hbat_pkg::factor_type factor,
   input  hbat_pkg::min_type    floor_bytes,
   output hbat_pkg::cnt_type    limit
);
   import hbat_pkg::*;

   localparam int PROD_BITS = COUNT_BITS + FACTOR_BITS;

   logic [PROD_BITS-1:0] prod;
   cnt_type              next_limit;
   cnt_type              floor_cnt;

   always_comb begin
      prod       = PROD_BITS'(bytes) * PROD_BITS'(factor);
      next_limit = (prod > PROD_BITS'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(prod);
      floor_cnt  = clamp_min(floor_bytes);
      limit      = (next_limit < floor_cnt) ? floor_cnt : next_limit;
   end

endmodule

`default_nettype wire

/* rtl/heap_byte_accounting_trigger.sv */
// Top level of the heap byte accounting trigger.
//
// Usage:
//   req channel: one beat per heap event (opcode, generation, sizes).
//   rsp channel: one beat per request with the pending flags, poll answer,
//   saturated total byte count and both collection thresholds after the event.
//   csr port: write-only, registers 0..3 (young factor, young floor, heap
//   factor, heap floor); write only while no beat is in flight.
// Path: an accepted request is held in the request register and then in the
//   response register, from which it is offered on rsp.
// Throughput: one beat per cycle unless rsp_stall holds the response; the counter
//   update, total sum, threshold compare and the 48 x 8 threshold multiply all sit
//   in a single stage between the request register and the response register.
// Reset (synchronous): counters and flags clear, thresholds load the reset
//   floor, factors load 2, both channels go empty.
// Stall: while rsp_stall holds the response, the request register keeps one
//   more beat and req_stall rises only once that register is occupied too.
`default_nettype none

module heap_byte_accounting_trigger (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_opcode,
   input  logic                      req_is_old_gen,
   input  hbat_pkg::size_type        req_first_size,
   input  hbat_pkg::size_type        req_second_size,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_young_pending,
   output logic                      rsp_full_pending,
   output logic [1:0]                rsp_collect_action,
   output hbat_pkg::out_type         rsp_total_bytes,
   output hbat_pkg::out_type         rsp_young_limit_out,
   output hbat_pkg::out_type         rsp_full_limit_out,
   // configuration
   input  logic                      csr_wr_en,
   input  hbat_pkg::csr_idx_type     csr_index,
   input  logic [hbat_pkg::CSR_BITS-1:0] csr_wdata
);
   import hbat_pkg::*;

   localparam int ADD_BITS = ((COUNT_BITS > SIZE_BITS) ? COUNT_BITS : SIZE_BITS) + 1;
   localparam int TOT_BITS = COUNT_BITS + 2;

   // configuration registers
   factor_type young_factor_ff;
   min_type    young_min_ff;
   factor_type heap_factor_ff;
   min_type    heap_min_ff;

   // request register
   logic       in_valid_ff;
   op_type     op_ff;
   logic       old_gen_ff;
   size_type   first_ff;
   size_type   second_ff;

   // accounting state
   cnt_type    young_ff, young_in;
   cnt_type    old_ff, old_in;
   cnt_type    env_ff, env_in;
   cnt_type    total_ff, total_in;
   cnt_type    young_limit_ff, young_limit_in;
   cnt_type    full_limit_ff, full_limit_in;
   logic       young_flag_ff, young_flag_in;
   logic       full_flag_ff, full_flag_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   action_type action_ff, action_in;

   logic       advance;
   logic       req_take;

   size_type                diff;
   logic                    grow;
   logic [ADD_BITS-1:0]     amount;
   cnt_type                 sel_cnt;
   logic [ADD_BITS-1:0]     sel_sum;
   cnt_type                 sel_sat;
   cnt_type                 sel_shrink;
   logic [ADD_BITS-1:0]     env_sum;
   cnt_type                 env_sat;
   logic [TOT_BITS-1:0]     tot_sum;
   logic                    chk_young;
   logic                    chk_full;

   cnt_type    th_bytes;
   factor_type th_factor;
   min_type    th_floor;
   cnt_type    th_limit;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // share one multiplier between the two recompute opcodes
   always_comb begin
      if (op_ff == OP_RECOMP_YNG) begin
         th_bytes  = young_ff;
         th_factor = young_factor_ff;
         th_floor  = young_min_ff;
      end else begin
         th_bytes  = total_ff;
         th_factor = heap_factor_ff;
         th_floor  = heap_min_ff;
      end
   end

   hbat_thresh u_thresh (
      .bytes       (th_bytes),
      .factor      (th_factor),
      .floor_bytes (th_floor),
      .limit       (th_limit)
   );

   always_comb begin
      grow       = second_ff > first_ff;
      diff       = grow ? (second_ff - first_ff) : (first_ff - second_ff);
      amount     = (op_ff == OP_ALLOC) ? ADD_BITS'(first_ff) : ADD_BITS'(diff);
      sel_cnt    = old_gen_ff ? old_ff : young_ff;
      sel_sum    = ADD_BITS'(sel_cnt) + amount;
      sel_sat    = (sel_sum > ADD_BITS'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(sel_sum);
      // subtract the shrink only while the counter stays above it
      sel_shrink = (ADD_BITS'(sel_cnt) > amount) ? (sel_cnt - COUNT_BITS'(amount)) : sel_cnt;
      env_sum    = ADD_BITS'(env_ff) + ADD_BITS'(first_ff);
      env_sat    = (env_sum > ADD_BITS'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(env_sum);

      young_in       = young_ff;
      old_in         = old_ff;
      env_in         = env_ff;
      young_limit_in = young_limit_ff;
      full_limit_in  = full_limit_ff;
      chk_young      = 1'b0;
      chk_full       = 1'b0;
      action_in      = ACT_NONE;
      young_flag_in  = young_flag_ff;
      full_flag_in   = full_flag_ff;

      case (op_ff)
         OP_ALLOC: begin
            if (old_gen_ff) begin
               old_in = sel_sat;
            end else begin
               young_in  = sel_sat;
               chk_young = 1'b1;
            end
            chk_full = 1'b1;
         end
         OP_RESIZE: begin
            if (first_ff != second_ff) begin
               if (old_gen_ff) begin
                  old_in = grow ? sel_sat : sel_shrink;
               end else begin
                  young_in  = grow ? sel_sat : sel_shrink;
                  chk_young = grow;
               end
               chk_full = 1'b1;
            end
         end
         OP_ENV_ALLOC: begin
            env_in   = env_sat;
            chk_full = 1'b1;
         end
         OP_POLL: begin
            if (full_flag_ff) begin
               action_in = ACT_FULL;
            end else if (young_flag_ff) begin
               action_in = ACT_YOUNG;
            end
         end
         OP_BEGIN: begin
            young_flag_in = 1'b0;
            full_flag_in  = 1'b0;
         end
         OP_RECOMP_YNG: begin
            young_limit_in = th_limit;
         end
         OP_RECOMP_FUL: begin
            full_limit_in = th_limit;
         end
         default: begin
         end
      endcase

      // nested saturating adds collapse to one clamp of the plain sum
      tot_sum  = TOT_BITS'(young_in) + TOT_BITS'(old_in) + TOT_BITS'(env_in);
      total_in = (tot_sum > TOT_BITS'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(tot_sum);

      if (chk_young && (young_in > young_limit_ff)) begin
         young_flag_in = 1'b1;
      end
      if (chk_full && (total_in > full_limit_ff)) begin
         full_flag_in = 1'b1;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         young_factor_ff <= RESET_FACTOR;
         young_min_ff    <= RESET_MIN_BYTES;
         heap_factor_ff  <= RESET_FACTOR;
         heap_min_ff     <= RESET_MIN_BYTES;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_YOUNG_FACTOR: young_factor_ff <= FACTOR_BITS'(csr_wdata);
            CSR_YOUNG_MIN:    young_min_ff    <= MIN_BITS'(csr_wdata);
            CSR_HEAP_FACTOR:  heap_factor_ff  <= FACTOR_BITS'(csr_wdata);
            CSR_HEAP_MIN:     heap_min_ff     <= MIN_BITS'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff      <= op_type'(req_opcode);
         old_gen_ff <= req_is_old_gen;
         first_ff   <= req_first_size;
         second_ff  <= req_second_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         young_ff       <= '0;
         old_ff         <= '0;
         env_ff         <= '0;
         total_ff       <= '0;
         young_limit_ff <= LIMIT_RESET;
         full_limit_ff  <= LIMIT_RESET;
         young_flag_ff  <= 1'b0;
         full_flag_ff   <= 1'b0;
      end else if (advance) begin
         young_ff       <= young_in;
         old_ff         <= old_in;
         env_ff         <= env_in;
         total_ff       <= total_in;
         young_limit_ff <= young_limit_in;
         full_limit_ff  <= full_limit_in;
         young_flag_ff  <= young_flag_in;
         full_flag_ff   <= full_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         action_ff <= action_in;
      end
   end

   // flags, total and limits in the response are the state registers themselves
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_young_pending   = young_flag_ff;
   assign rsp_full_pending    = full_flag_ff;
   assign rsp_collect_action  = action_ff;
   assign rsp_total_bytes     = OUT_BITS'(total_ff);
   assign rsp_young_limit_out = OUT_BITS'(young_limit_ff);
   assign rsp_full_limit_out  = OUT_BITS'(full_limit_ff);

endmodule

`default_nettype wire

/* rtl/hbat_checker.sv */
// Port-level assertion checker for the heap byte accounting trigger, with its bind.
`default_nettype none

`include "assert_macros.svh"

module hbat_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic                      rsp_young_pending,
   input logic                      rsp_full_pending,
   input logic [1:0]                rsp_collect_action,
   input hbat_pkg::out_type         rsp_total_bytes,
   input hbat_pkg::out_type         rsp_full_limit_out
);
   import hbat_pkg::*;

   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "response valid after reset")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_total_bytes) && $stable(rsp_collect_action) && $stable(rsp_full_limit_out), "stalled response changed")
   `ASSERT_IMPL(a_full_action, clock, reset, rsp_valid && (rsp_collect_action == ACT_FULL), rsp_full_pending, "full answer without full pending")
   `ASSERT_IMPL(a_young_action, clock, reset, rsp_valid && (rsp_collect_action == ACT_YOUNG), rsp_young_pending && !rsp_full_pending, "young answer with wrong flags")

endmodule

bind heap_byte_accounting_trigger hbat_checker u_hbat_checker (.*);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench: directed, random and saturating heap events against a local predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hbat_pkg::*;

   localparam logic [2:0] OP_UNUSED      = 3'd7;
   localparam size_type   SIZE_TOP       = '1;
   localparam int         CYCLE_LIMIT    = 100_000;
   // enough top-size beats to push a times-255 product past the counter maximum
   localparam int         SAT_BEATS      = 260;
   localparam int         SAT_SIDE_BEATS = 4;
   localparam int         TRAFFIC_EVENTS = 180;

   typedef struct {
      logic       young_pending;
      logic       full_pending;
      logic [1:0] action;
      out_type    total;
      out_type    young_limit;
      out_type    full_limit;
   } heap_report_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [2:0]          req_opcode;
   logic                req_is_old_gen;
   size_type            req_first_size;
   size_type            req_second_size;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_young_pending;
   logic                rsp_full_pending;
   logic [1:0]          rsp_collect_action;
   out_type             rsp_total_bytes;
   out_type             rsp_young_limit_out;
   out_type             rsp_full_limit_out;
   logic                csr_wr_en;
   csr_idx_type         csr_index;
   logic [CSR_BITS-1:0] csr_wdata;

   // predictor state and its copy of the registers
   cnt_type    young_bytes  = '0;
   cnt_type    old_bytes    = '0;
   cnt_type    env_bytes    = '0;
   cnt_type    young_thresh = cnt_type'(RESET_MIN_BYTES);
   cnt_type    full_thresh  = cnt_type'(RESET_MIN_BYTES);
   logic       young_due    = 1'b0;
   logic       full_due     = 1'b0;
   factor_type young_factor = RESET_FACTOR;
   factor_type heap_factor  = RESET_FACTOR;
   min_type    young_floor  = RESET_MIN_BYTES;
   min_type    heap_floor   = RESET_MIN_BYTES;

   heap_report_type awaited_reports[$];
   heap_report_type oldest_report;
   int           mismatches    = 0;
   int           cycle_count   = 0;
   int           rsp_hold_left = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  stall_pct     = 0;

   heap_byte_accounting_trigger i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_is_old_gen     (req_is_old_gen),
      .req_first_size     (req_first_size),
      .req_second_size    (req_second_size),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_young_pending  (rsp_young_pending),
      .rsp_full_pending   (rsp_full_pending),
      .rsp_collect_action (rsp_collect_action),
      .rsp_total_bytes    (rsp_total_bytes),
      .rsp_young_limit_out(rsp_young_limit_out),
      .rsp_full_limit_out (rsp_full_limit_out),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic cnt_type sat_sum(input cnt_type a, input cnt_type b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
   endfunction

   function automatic cnt_type heap_total();
      return sat_sum(sat_sum(young_bytes, old_bytes), env_bytes);
   endfunction

   function automatic cnt_type next_threshold(input cnt_type bytes, input factor_type factor,
                                              input min_type floor_v);
      logic [COUNT_BITS+FACTOR_BITS-1:0] prod;
      cnt_type                           grown;
      prod  = (COUNT_BITS+FACTOR_BITS)'(bytes) * (COUNT_BITS+FACTOR_BITS)'(factor);
      grown = (prod > CNT_MAX) ? CNT_MAX : prod[COUNT_BITS-1:0];
      return (grown < cnt_type'(floor_v)) ? cnt_type'(floor_v) : grown;
   endfunction

   function automatic void note_young();
      if (young_bytes > young_thresh) young_due = 1'b1;
   endfunction

   function automatic void note_full();
      if (heap_total() > full_thresh) full_due = 1'b1;
   endfunction

   function automatic void account_event(input logic [2:0] op, input logic old_gen,
                                         input size_type first, input size_type second);
      heap_report_type rep;
      cnt_type      delta;
      rep.action = ACT_NONE;
      case (op)
         OP_ALLOC: begin
            if (old_gen) begin
               old_bytes = sat_sum(old_bytes, cnt_type'(first));
            end else begin
               young_bytes = sat_sum(young_bytes, cnt_type'(first));
               note_young();
            end
            note_full();
         end
         OP_RESIZE: begin
            if (first != second) begin
               if (second > first) begin
                  delta = cnt_type'(second - first);
                  if (old_gen) begin
                     old_bytes = sat_sum(old_bytes, delta);
                  end else begin
                     young_bytes = sat_sum(young_bytes, delta);
                     note_young();
                  end
               end else begin
                  // shrink only while the counter is strictly larger
                  delta = cnt_type'(first - second);
                  if (old_gen) begin
                     if (old_bytes > delta) old_bytes = old_bytes - delta;
                  end else begin
                     if (young_bytes > delta) young_bytes = young_bytes - delta;
                  end
               end
               note_full();
            end
         end
         OP_ENV_ALLOC: begin
            env_bytes = sat_sum(env_bytes, cnt_type'(first));
            note_full();
         end
         OP_POLL: begin
            rep.action = full_due ? ACT_FULL : (young_due ? ACT_YOUNG : ACT_NONE);
         end
         OP_BEGIN: begin
            young_due = 1'b0;
            full_due  = 1'b0;
         end
         OP_RECOMP_YNG: young_thresh = next_threshold(young_bytes, young_factor, young_floor);
         OP_RECOMP_FUL: full_thresh = next_threshold(heap_total(), heap_factor, heap_floor);
         default: ;
      endcase
      rep.young_pending = young_due;
      rep.full_pending  = full_due;
      rep.total         = out_type'(heap_total());
      rep.young_limit   = out_type'(young_thresh);
      rep.full_limit    = out_type'(full_thresh);
      awaited_reports.push_back(rep);
   endfunction

   // -------------------------------------------------------- monitors, checks

   always @(posedge clock) begin
      if (!reset && req_valid === 1'b1 && req_stall === 1'b0) begin
         account_event(req_opcode, req_is_old_gen, req_first_size, req_second_size);
      end
   end

   task automatic compare_field(input string name, input logic [OUT_BITS-1:0] want,
                                input logic [OUT_BITS-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 50) begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 50) begin
               $display("%0t ns: response beat with nothing awaited", $time);
            end
         end else begin
            oldest_report = awaited_reports.pop_front();
            compare_field("young_pending", OUT_BITS'(oldest_report.young_pending),
                          OUT_BITS'(rsp_young_pending));
            compare_field("full_pending", OUT_BITS'(oldest_report.full_pending),
                          OUT_BITS'(rsp_full_pending));
            compare_field("collect_action", OUT_BITS'(oldest_report.action),
                          OUT_BITS'(rsp_collect_action));
            compare_field("total_bytes", oldest_report.total, rsp_total_bytes);
            compare_field("young_limit_out", oldest_report.young_limit, rsp_young_limit_out);
            compare_field("full_limit_out", oldest_report.full_limit, rsp_full_limit_out);
         end
      end
   end

   // receiver: random stall, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------- stimulus

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_event(input logic [2:0] op, input logic old_gen,
                             input size_type first, input size_type second);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_is_old_gen  <= old_gen;
      req_first_size  <= first;
      req_second_size <= second;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   task automatic drain_reports();
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write all four registers; only called while nothing is in flight.
   task automatic configure(input logic [CSR_BITS-1:0] yf_word, input min_type ym,
                            input logic [CSR_BITS-1:0] hf_word, input min_type hm);
      logic [CSR_BITS-1:0] words [4];
      words[CSR_YOUNG_FACTOR] = yf_word;
      words[CSR_YOUNG_MIN]    = ym;
      words[CSR_HEAP_FACTOR]  = hf_word;
      words[CSR_HEAP_MIN]     = hm;
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_idx_type'(i);
         csr_wdata <= words[i];
         @(posedge clock);
         case (csr_idx_type'(i))
            CSR_YOUNG_FACTOR: young_factor = words[i][FACTOR_BITS-1:0];
            CSR_YOUNG_MIN:    young_floor  = words[i][MIN_BITS-1:0];
            CSR_HEAP_FACTOR:  heap_factor  = words[i][FACTOR_BITS-1:0];
            CSR_HEAP_MIN:     heap_floor   = words[i][MIN_BITS-1:0];
            default: ;
         endcase
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic size_type pick_size();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 45) return size_type'($urandom_range(4095));
      if (r < 75) return size_type'($urandom_range(2097151));
      if (r < 85) return $urandom_range(1) ? SIZE_TOP : '0;
      return size_type'($urandom);
   endfunction

   task automatic random_event();
      int unsigned r;
      size_type    a;
      size_type    b;
      logic        g;
      r = $urandom_range(99);
      a = pick_size();
      b = pick_size();
      g = 1'($urandom_range(1));
      if (r < 6) begin
         // a full collection cycle as a collector would run it
         send_event(OP_POLL, g, a, b);
         send_event(OP_BEGIN, ~g, b, a);
         send_event(OP_RECOMP_YNG, g, a, a);
         send_event(OP_RECOMP_FUL, ~g, b, b);
      end else if (r < 36) begin
         send_event(OP_ALLOC, g, a, b);
      end else if (r < 58) begin
         if ($urandom_range(6) == 0) b = a;
         send_event(OP_RESIZE, g, a, b);
      end else if (r < 68) begin
         send_event(OP_ENV_ALLOC, g, a, b);
      end else if (r < 78) begin
         send_event(OP_POLL, g, a, b);
      end else if (r < 84) begin
         send_event(OP_BEGIN, g, a, b);
      end else if (r < 90) begin
         send_event(OP_RECOMP_YNG, g, a, b);
      end else if (r < 96) begin
         send_event(OP_RECOMP_FUL, g, a, b);
      end else begin
         send_event(OP_UNUSED, g, a, b);
      end
   endtask

   task automatic run_traffic(input int count);
      repeat (count) random_event();
   endtask

   // ----------------------------------------------------------------- tests

   // Reset register values; walks flags, poll priority, shrink rules, unused opcode.
   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_event(OP_POLL, 1'b0, '0, '0);
      send_event(OP_ALLOC, 1'b0, '0, SIZE_TOP);
      send_event(OP_RESIZE, 1'b0, '0, '0);
      send_event(OP_RESIZE, 1'b0, 32'd100, '0);
      send_event(OP_ALLOC, 1'b1, SIZE_TOP, '0);
      send_event(OP_POLL, 1'b1, SIZE_TOP, SIZE_TOP);
      send_event(OP_BEGIN, 1'b0, '0, '0);
      send_event(OP_RECOMP_FUL, 1'b0, '0, '0);
      send_event(OP_ALLOC, 1'b0, 32'h0010_0001, SIZE_TOP);
      send_event(OP_POLL, 1'b0, '0, '0);
      send_event(OP_RECOMP_YNG, 1'b1, SIZE_TOP, SIZE_TOP);
      send_event(OP_RESIZE, 1'b0, '0, SIZE_TOP);
      send_event(OP_POLL, 1'b0, '0, '0);
      send_event(OP_RESIZE, 1'b1, SIZE_TOP, SIZE_TOP);
      send_event(OP_RESIZE, 1'b1, SIZE_TOP, 32'd1);
      send_event(OP_RESIZE, 1'b1, 32'd10, '0);
      send_event(OP_ENV_ALLOC, 1'b1, 32'd12345, SIZE_TOP);
      send_event(OP_UNUSED, 1'b1, SIZE_TOP, SIZE_TOP);
      send_event(OP_BEGIN, 1'b1, SIZE_TOP, SIZE_TOP);
      send_event(OP_POLL, 1'b0, '0, '0);
      send_event(OP_RESIZE, 1'b1, 32'd5, 32'd1000);
      send_event(OP_RECOMP_YNG, 1'b0, '0, '0);
      send_event(OP_RECOMP_FUL, 1'b0, '0, '0);
      send_event(OP_POLL, 1'b0, '0, '0);
      drain_reports();
   endtask

   // Hold the response side off long enough to fill the block and stall requests.
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      @(posedge clock);
      rsp_hold_left = 300;
      @(negedge clock);
      run_traffic(40);
      drain_reports();
   endtask

   task automatic test_steady_traffic();
      configure(48'd2, RESET_MIN_BYTES, 48'd2, RESET_MIN_BYTES);
      send_idle_pct = 0;
      stall_pct     = 0;
      run_traffic(TRAFFIC_EVENTS);
      drain_reports();
   endtask

   // Upper write-data bits above a factor must be dropped.
   task automatic test_sparse_sender();
      configure(48'hFFFF_FFFF_FF01, '0, 48'hA5A5_0000_00FF, '1);
      send_idle_pct = 86;
      stall_pct     = 0;
      run_traffic(TRAFFIC_EVENTS);
      drain_reports();
   endtask

   // Zero factors: every recompute falls back to the floor.
   task automatic test_slow_receiver();
      configure(48'd0, 48'd4096, 48'd0, 48'd65536);
      send_idle_pct = 0;
      stall_pct     = 86;
      run_traffic(TRAFFIC_EVENTS);
      drain_reports();
   endtask

   task automatic test_mixed_idling();
      configure(48'd255, 48'h0000_FFFF_FFFF, 48'($urandom_range(255)),
                min_type'({$urandom, $urandom}));
      send_idle_pct = 16;
      stall_pct     = 16;
      run_traffic(TRAFFIC_EVENTS);
      drain_reports();
   endtask

   // Push both threshold products past the counter maximum, then shrink from the top.
   task automatic test_saturation();
      configure(48'd255, '0, 48'd255, '0);
      send_idle_pct = 0;
      stall_pct     = 0;
      for (int k = 0; k < SAT_BEATS; k++) send_event(OP_ALLOC, 1'b0, SIZE_TOP, '0);
      send_event(OP_RECOMP_YNG, 1'b0, '0, '0);
      send_event(OP_RECOMP_FUL, 1'b0, '0, '0);
      for (int k = 0; k < SAT_SIDE_BEATS; k++) send_event(OP_ALLOC, 1'b1, SIZE_TOP, '0);
      for (int k = 0; k < SAT_SIDE_BEATS; k++) send_event(OP_ENV_ALLOC, 1'b0, SIZE_TOP, '0);
      send_event(OP_RESIZE, 1'b0, SIZE_TOP, '0);
      send_event(OP_RESIZE, 1'b1, SIZE_TOP, '0);
      send_event(OP_POLL, 1'b0, '0, '0);
      send_event(OP_RECOMP_FUL, 1'b0, '0, '0);
      drain_reports();
      configure(48'd1, '1, 48'd3, '1);
      send_idle_pct = 16;
      stall_pct     = 16;
      run_traffic(100);
      drain_reports();
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OP_ALLOC;
      req_is_old_gen  = 1'b0;
      req_first_size  = '0;
      req_second_size = '0;
      rsp_stall       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_YOUNG_FACTOR;
      csr_wdata       = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_backpressure();
      test_steady_traffic();
      test_sparse_sender();
      test_slow_receiver();
      test_mixed_idling();
      test_saturation();

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
